### hdl/hmad_pkg.sv
// ----------------------------------------------------------------------------
// hmad_pkg
// Shared types, constants and the control store for the histogram median
// absolute deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package hmad_pkg;

   localparam int BIN_W = 24;
   localparam int MED_W = 7;
   localparam int MAD_W = 24;

   // 1.4826 in Q16 over a decimal scale of 10000: 14826 * 65536
   localparam int MAD_K_W = 30;
   localparam logic [MAD_K_W-1:0] MAD_K = 30'd971636736;
   localparam int DEN_SCALE = 10000;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MED_INIT,
      OP_MED_RD,
      OP_MED_ACC,
      OP_DEV_INIT,
      OP_DEV_RD,
      OP_DEV_ACC,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_JUMP,
      COND_WAIT,
      COND_LOOP
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_MED_INIT = 4'd1;
   localparam step_type STEP_MED_RD   = 4'd2;
   localparam step_type STEP_MED_ACC  = 4'd3;
   localparam step_type STEP_DEV_INIT = 4'd4;
   localparam step_type STEP_DEV_RD   = 4'd5;
   localparam step_type STEP_DEV_ACC  = 4'd6;
   localparam step_type STEP_EMIT     = 4'd7;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_type;

   // control store: one word per step
   function automatic ctl_type prog_word(input step_type step);
      ctl_type w;
      w.op     = OP_NOP;
      w.cond   = COND_JUMP;
      w.target = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.op   = OP_NOP;
            w.cond = COND_WAIT;
         end
         STEP_MED_INIT: begin
            w.op   = OP_MED_INIT;
            w.cond = COND_NEXT;
         end
         STEP_MED_RD: begin
            w.op   = OP_MED_RD;
            w.cond = COND_NEXT;
         end
         STEP_MED_ACC: begin
            w.op     = OP_MED_ACC;
            w.cond   = COND_LOOP;
            w.target = STEP_MED_RD;
         end
         STEP_DEV_INIT: begin
            w.op   = OP_DEV_INIT;
            w.cond = COND_NEXT;
         end
         STEP_DEV_RD: begin
            w.op   = OP_DEV_RD;
            w.cond = COND_NEXT;
         end
         STEP_DEV_ACC: begin
            w.op     = OP_DEV_ACC;
            w.cond   = COND_LOOP;
            w.target = STEP_DEV_RD;
         end
         STEP_EMIT: begin
            w.op     = OP_EMIT;
            w.cond   = COND_JUMP;
            w.target = STEP_IDLE;
         end
         default: begin
            w.op     = OP_NOP;
            w.cond   = COND_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hdl/histogram_median_abs_deviation_top.sv
// ----------------------------------------------------------------------------
// histogram_median_abs_deviation_top
// Median bin and median absolute deviation of a histogram fed bin by bin.
//
// Input: one bin count word per cycle on req_bin_count, taken when start is
// high and busy is low; req_last_bin marks the final bin. Bins past
// NUM_BINS are dropped, bins never sent count zero.
// Non-final bins leave busy low. After the final bin busy stays high while
// two memory scans run through the bin store, each stepping a bin through a
// read step and an accumulate step: one finds the median bin, the other the
// deviation bin; the scaled deviation is built alongside the second scan.
// The result word is on the rsp_ ports for one cycle with rsp_valid high, in
// the cycle busy drops; the receiver cannot stall it. The next histogram may
// start in that same cycle. Stores are empty again after each result.
// Reset clears the sequencer, fill count and total; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_median_abs_deviation_top
   import hmad_pkg::*;
#(
   parameter int NUM_BINS  = 128,
   parameter int PRECISION = 100
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [BIN_W-1:0] req_bin_count,
   input  wire logic             req_last_bin,
   output logic                  rsp_valid,
   output logic      [MED_W-1:0] rsp_median_bin,
   output logic      [MED_W-1:0] rsp_deviation_bin,
   output logic      [MAD_W-1:0] rsp_mad_scaled
);

   ctl_type ctl;
   logic    loop_end;
   logic    load_en;
   logic    go;

   assign load_en = start && !busy;
   assign go      = start && req_last_bin;

   hmad_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .loop_end (loop_end),
      .ctl      (ctl),
      .busy     (busy)
   );

   hmad_dp #(
      .NUM_BINS  (NUM_BINS),
      .PRECISION (PRECISION)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .load_en           (load_en),
      .load_count        (req_bin_count),
      .loop_end          (loop_end),
      .rsp_valid         (rsp_valid),
      .rsp_median_bin    (rsp_median_bin),
      .rsp_deviation_bin (rsp_deviation_bin),
      .rsp_mad_scaled    (rsp_mad_scaled)
   );

`ifndef SYNTHESIS
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_done_has_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("compute ended without a result");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while sequencer busy");

   a_zero_dev : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_deviation_bin == '0 && NUM_BINS <= 128)
         |-> rsp_mad_scaled == '0)
      else $error("nonzero scaled deviation for zero deviation");
`endif

endmodule

`default_nettype wire

### hdl/hmad_bin_mem.sv
// ----------------------------------------------------------------------------
// hmad_bin_mem
// Bin count store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module hmad_bin_mem
   import hmad_pkg::*;
#(
   parameter int DEPTH = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BIN_W-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [BIN_W-1:0]  rd_data_a,
   output logic      [BIN_W-1:0]  rd_data_b
);

   logic [BIN_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

### hdl/hmad_seq.sv
// ----------------------------------------------------------------------------
// hmad_seq
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module hmad_seq
   import hmad_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic go,
   input  wire logic loop_end,
   output ctl_type   ctl,
   output logic      busy
);

   step_type step_ff;
   step_type step_in;
   step_type step_inc;

   assign ctl      = prog_word(step_ff);
   assign busy     = (step_ff != STEP_IDLE);
   assign step_inc = step_type'(step_ff + 1'b1);

   always_comb begin
      unique case (ctl.cond)
         COND_NEXT: step_in = step_inc;
         COND_JUMP: step_in = ctl.target;
         COND_WAIT: step_in = go ? step_inc : step_ff;
         COND_LOOP: step_in = loop_end ? step_inc : ctl.target;
         default:   step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### hdl/hmad_dp.sv
// ----------------------------------------------------------------------------
// hmad_dp
// Datapath: bin loading, running-count scans for both medians, constant
// scaling by a running quotient and remainder, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hmad_dp
   import hmad_pkg::*;
#(
   parameter int NUM_BINS  = 128,
   parameter int PRECISION = 100
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctl_type          ctl,
   input  wire logic             load_en,
   input  wire logic [BIN_W-1:0] load_count,
   output logic                  loop_end,
   output logic                  rsp_valid,
   output logic      [MED_W-1:0] rsp_median_bin,
   output logic      [MED_W-1:0] rsp_deviation_bin,
   output logic      [MAD_W-1:0] rsp_mad_scaled
);

   localparam int    IDX_W  = $clog2(NUM_BINS);
   localparam int    FILL_W = IDX_W + 1;
   localparam int    TOT_W  = BIN_W + IDX_W;
   localparam int    NUM_W  = IDX_W + MAD_K_W;
   localparam longint DEN   = longint'(DEN_SCALE) * longint'(PRECISION);
   localparam int    DEN_W  = $clog2(DEN + 1);
   localparam int    REM_W  = DEN_W + 1;
   localparam longint STEP_Q = longint'(MAD_K) / DEN;
   localparam longint STEP_R = longint'(MAD_K) % DEN;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(NUM_BINS);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NUM_BINS - 1);
   localparam logic [REM_W-1:0]  DEN_R    = REM_W'(DEN);
   localparam logic [NUM_W-1:0]  MAD_Q    = NUM_W'(STEP_Q);
   localparam logic [REM_W-1:0]  MAD_R    = REM_W'(STEP_R);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  target_ff, target_in;
   logic [TOT_W-1:0]  run_ff, run_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  median_ff, median_in;
   logic [IDX_W-1:0]  dev_ff, dev_in;
   logic              a_ok_ff, a_ok_in;
   logic              b_ok_ff, b_ok_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MED_W-1:0]  rsp_median_ff, rsp_median_in;
   logic [MED_W-1:0]  rsp_dev_ff, rsp_dev_in;
   logic [MAD_W-1:0]  rsp_mad_ff, rsp_mad_in;

   logic              room;
   logic              wr_en;
   logic [IDX_W-1:0]  lo_addr;
   logic [FILL_W-1:0] hi_sum;
   logic [IDX_W-1:0]  rd_addr_a;
   logic [BIN_W-1:0]  rd_data_a, rd_data_b;
   logic [BIN_W:0]    rd_sum;
   logic [TOT_W-1:0]  run_next;
   logic              hit;
   logic [REM_W-1:0]  rem_add;
   logic              rem_ge;

   assign room    = (fill_ff < FILL_MAX);
   assign wr_en   = load_en && room;
   assign lo_addr = median_ff - scan_ff;
   assign hi_sum  = {1'b0, median_ff} + {1'b0, scan_ff};
   assign rd_addr_a = (ctl.op == OP_MED_RD) ? scan_ff : lo_addr;

   hmad_bin_mem #(
      .DEPTH(NUM_BINS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (fill_ff[IDX_W-1:0]),
      .wr_data   (load_count),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (hi_sum[IDX_W-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // entries at or past the fill count read as zero
   assign rd_sum   = (a_ok_ff ? {1'b0, rd_data_a} : '0) + (b_ok_ff ? {1'b0, rd_data_b} : '0);
   assign run_next = run_ff + TOT_W'(rd_sum);
   assign hit      = (run_next >= target_ff) || (scan_ff == IDX_LAST);

   assign rem_add = rem_ff + MAD_R;
   assign rem_ge  = (rem_add >= DEN_R);

   always_comb begin
      unique case (ctl.op)
         OP_MED_ACC, OP_DEV_ACC: loop_end = hit;
         default:                loop_end = 1'b0;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      run_in        = run_ff;
      scan_in       = scan_ff;
      median_in     = median_ff;
      dev_in        = dev_ff;
      a_ok_in       = a_ok_ff;
      b_ok_in       = b_ok_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = 1'b0;
      rsp_median_in = rsp_median_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_mad_in    = rsp_mad_ff;

      if (wr_en) begin
         fill_in  = fill_ff + 1'b1;
         total_in = total_ff + TOT_W'(load_count);
      end

      unique case (ctl.op)
         OP_NOP: begin
         end
         OP_MED_INIT: begin
            run_in    = '0;
            scan_in   = '0;
            target_in = (total_ff >> 1) + TOT_W'(total_ff[0]);
         end
         OP_MED_RD: begin
            a_ok_in = ({1'b0, scan_ff} < fill_ff);
            b_ok_in = 1'b0;
         end
         OP_MED_ACC: begin
            run_in = run_next;
            if (hit) begin
               median_in = scan_ff;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         OP_DEV_INIT: begin
            run_in  = '0;
            scan_in = '0;
            num_in  = '0;
            rem_in  = '0;
         end
         OP_DEV_RD: begin
            // lower and upper neighbors at this distance; center counted once
            a_ok_in = (scan_ff <= median_ff) && ({1'b0, lo_addr} < fill_ff);
            b_ok_in = (scan_ff != '0) && (hi_sum < fill_ff);
         end
         OP_DEV_ACC: begin
            run_in = run_next;
            if (hit) begin
               dev_in = scan_ff;
            end else begin
               scan_in = scan_ff + 1'b1;
               // scaled value follows the scan: quotient and remainder of k*scan
               num_in  = num_ff + MAD_Q + NUM_W'(rem_ge);
               rem_in  = rem_ge ? (rem_add - DEN_R) : rem_add;
            end
         end
         OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_median_in = MED_W'(median_ff);
            rsp_dev_in    = MED_W'(dev_ff);
            rsp_mad_in    = (|num_ff[NUM_W-1:MAD_W]) ? '1 : num_ff[MAD_W-1:0];
            fill_in       = '0;
            total_in      = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      run_ff        <= run_in;
      scan_ff       <= scan_in;
      median_ff     <= median_in;
      dev_ff        <= dev_in;
      a_ok_ff       <= a_ok_in;
      b_ok_ff       <= b_ok_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      rsp_median_ff <= rsp_median_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_mad_ff    <= rsp_mad_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_bin    = rsp_median_ff;
   assign rsp_deviation_bin = rsp_dev_ff;
   assign rsp_mad_scaled    = rsp_mad_ff;

endmodule

`default_nettype wire
